[rtl/core/cdq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and codes for the circular deque
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int unsigned OpWidth     = 2;
    localparam int unsigned StatusWidth = 2;

    typedef enum logic [OpWidth-1:0] {
        OP_PUSH_REAR  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_REAR   = 2'd2,
        OP_POP_FRONT  = 2'd3
    } t_op;

    typedef enum logic [StatusWidth-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic push_rear;
        logic push_front;
        logic pop_rear;
        logic pop_front;
        logic shift;
    } t_cell_ctl;

endpackage

[rtl/core/cdq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_cell
// one slot of the deque row, with a hand-off stage for rear pops
// ----------------------------------------------------------------------------
module cdq_cell
    import cdq_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [DATA_WIDTH-1:0] i_din,
    input  logic [DATA_WIDTH-1:0] i_prev_data,
    input  logic                  i_prev_valid,
    input  logic [DATA_WIDTH-1:0] i_next_data,
    input  logic                  i_next_valid,
    input  logic [DATA_WIDTH-1:0] i_next_hand,
    input  logic                  i_next_tok,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_hand,
    output logic                  o_tok
);

    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic                  r_valid, n_valid;
    logic [DATA_WIDTH-1:0] r_hand, n_hand;
    logic                  r_tok, n_tok;
    logic                  w_rear_free;
    logic                  w_rear_last;

    // this cell is the first empty slot / the last occupied slot
    assign w_rear_free = !r_valid && i_prev_valid;
    assign w_rear_last = r_valid && !i_next_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        n_hand  = r_hand;
        n_tok   = r_tok;
        if (i_ctl.push_front) begin
            n_data  = i_prev_data;
            n_valid = i_prev_valid;
        end else if (i_ctl.pop_front) begin
            n_data  = i_next_data;
            n_valid = i_next_valid;
        end else if (i_ctl.push_rear && w_rear_free) begin
            n_data  = i_din;
            n_valid = 1'b1;
        end else if (i_ctl.pop_rear && w_rear_last) begin
            n_valid = 1'b0;
            n_hand  = r_data;
            n_tok   = 1'b1;
        end else if (i_ctl.shift) begin
            n_hand  = i_next_hand;
            n_tok   = i_next_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_hand <= n_hand;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_hand  = r_hand;
    assign o_tok   = r_tok;

endmodule

[rtl/core/cdq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl
// request decode, occupancy count, result register and rear-pop wait
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32,
    localparam int unsigned CntWidth  = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  t_op                   i_opcode,
    input  logic                  i_res_ready,
    output logic                  o_res_valid,
    output t_status               o_status,
    output logic [DATA_WIDTH-1:0] o_data_out,
    output logic [CntWidth-1:0]   o_occupancy,
    input  logic [DATA_WIDTH-1:0] i_front_data,
    input  logic [DATA_WIDTH-1:0] i_hand,
    input  logic                  i_tok,
    output t_cell_ctl             o_ctl
);

    t_state                r_state, n_state;
    logic [CntWidth-1:0]   r_count, n_count;
    logic                  r_res_valid, n_res_valid;
    t_status               r_status, n_status;
    logic [DATA_WIDTH-1:0] r_data_out, n_data_out;
    logic [CntWidth-1:0]   r_occ, n_occ;
    logic                  w_out_free;
    logic                  w_accept;
    logic                  w_is_push;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_ok;
    logic                  w_load;

    assign w_out_free = !r_res_valid || i_res_ready;
    assign w_is_push  = (i_opcode == OP_PUSH_REAR) || (i_opcode == OP_PUSH_FRONT);
    assign w_full     = (r_count == CntWidth'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_ok       = w_is_push ? !w_full : !w_empty;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_status    = r_status;
        n_data_out  = r_data_out;
        n_occ       = r_occ;
        o_req_ready = 1'b0;
        o_ctl       = '0;
        w_accept    = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = w_out_free;
                w_accept    = i_req_valid && w_out_free;
                if (w_accept) begin
                    n_status   = w_ok ? ST_OK : (w_is_push ? ST_OVERFLOW : ST_UNDERFLOW);
                    n_data_out = '0;
                    if (w_ok) begin
                        n_count = w_is_push ? r_count + 1'b1 : r_count - 1'b1;
                    end
                    n_occ = n_count;
                    o_ctl.push_rear  = w_ok && (i_opcode == OP_PUSH_REAR);
                    o_ctl.push_front = w_ok && (i_opcode == OP_PUSH_FRONT);
                    o_ctl.pop_rear   = w_ok && (i_opcode == OP_POP_REAR);
                    o_ctl.pop_front  = w_ok && (i_opcode == OP_POP_FRONT);
                    if (o_ctl.pop_front) begin
                        n_data_out = i_front_data;
                    end
                    if (o_ctl.pop_rear) begin
                        n_state = S_DRAIN;
                    end else begin
                        w_load = 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                o_ctl.shift = !i_tok || w_out_free;
                if (i_tok && w_out_free) begin
                    w_load     = 1'b1;
                    n_status   = ST_OK;
                    n_data_out = i_hand;
                    n_occ      = r_count;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_res_valid = w_load || (r_res_valid && !i_res_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_data_out <= n_data_out;
        r_occ      <= n_occ;
    end

    assign o_res_valid = r_res_valid;
    assign o_status    = r_status;
    assign o_data_out  = r_data_out;
    assign o_occupancy = r_occ;

endmodule

[rtl/core/circular_deque.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue of DEPTH words held in a row of shifting cells
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: an opcode (push rear, push front,
// pop rear, pop front) and a data word. Each request gives one result on
// m_axis: a status (ok, overflow, underflow), the popped word (zero unless
// a pop succeeded) and the occupancy after the step.
// The front word always sits in cell 0; a front push or pop shifts the whole
// row by one cell, a rear push fills the first empty cell.
// Pushes, front pops and failed requests show their result in the cycle
// after the request is taken. A rear pop hands the word down the row
// one cell per cycle to cell 0, from where its result is loaded.
// Throughput: one request per cycle while m_axis is not stalled; after a
// successful rear pop the next request waits until its result is loaded.
// The result register decouples the sides: a new request is taken while a
// result is held, as long as the register is free or drains that cycle.
// A stalled receiver holds the result and the block takes no new request.
// Reset empties the deque; cell data is not cleared.
// ----------------------------------------------------------------------------
module circular_deque
    import cdq_pkg::*;
#(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32,
    localparam int unsigned CntWidth  = $clog2(DEPTH + 1),
    localparam int unsigned InWidth   = ((OpWidth + DATA_WIDTH + 7) / 8) * 8,
    localparam int unsigned OutWidth  = ((StatusWidth + DATA_WIDTH + CntWidth + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InWidth-1:0]  s_axis_tdata,   // opcode, data_in
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutWidth-1:0] m_axis_tdata    // status, data_out, occupancy
);

    t_op                   w_opcode;
    logic [DATA_WIDTH-1:0] w_din;
    t_status               w_status;
    logic [DATA_WIDTH-1:0] w_data_out;
    logic [CntWidth-1:0]   w_occ;
    t_cell_ctl             w_ctl;
    logic [DATA_WIDTH-1:0] w_data  [DEPTH];
    logic                  w_valid [DEPTH];
    logic [DATA_WIDTH-1:0] w_hand  [DEPTH];
    logic                  w_tok   [DEPTH];

    assign w_opcode = t_op'(s_axis_tdata[OpWidth-1:0]);
    assign w_din    = s_axis_tdata[OpWidth +: DATA_WIDTH];

    cdq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_opcode     (w_opcode),
        .i_res_ready  (m_axis_tready),
        .o_res_valid  (m_axis_tvalid),
        .o_status     (w_status),
        .o_data_out   (w_data_out),
        .o_occupancy  (w_occ),
        .i_front_data (w_data[0]),
        .i_hand       (w_hand[0]),
        .i_tok        (w_tok[0]),
        .o_ctl        (w_ctl)
    );

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_prev_data;
        logic                  w_prev_valid;
        logic [DATA_WIDTH-1:0] w_next_data;
        logic                  w_next_valid;
        logic [DATA_WIDTH-1:0] w_next_hand;
        logic                  w_next_tok;

        if (k == 0) begin : g_first
            assign w_prev_data  = w_din;
            assign w_prev_valid = 1'b1;
        end else begin : g_mid_prev
            assign w_prev_data  = w_data[k-1];
            assign w_prev_valid = w_valid[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign w_next_data  = '0;
            assign w_next_valid = 1'b0;
            assign w_next_hand  = '0;
            assign w_next_tok   = 1'b0;
        end else begin : g_mid_next
            assign w_next_data  = w_data[k+1];
            assign w_next_valid = w_valid[k+1];
            assign w_next_hand  = w_hand[k+1];
            assign w_next_tok   = w_tok[k+1];
        end

        cdq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_din        (w_din),
            .i_prev_data  (w_prev_data),
            .i_prev_valid (w_prev_valid),
            .i_next_data  (w_next_data),
            .i_next_valid (w_next_valid),
            .i_next_hand  (w_next_hand),
            .i_next_tok   (w_next_tok),
            .o_data       (w_data[k]),
            .o_valid      (w_valid[k]),
            .o_hand       (w_hand[k]),
            .o_tok        (w_tok[k])
        );
    end

    assign m_axis_tdata = OutWidth'({w_occ, w_data_out, w_status});

endmodule
